FILE: hw/rtl/sls_pkg.sv
// ============================================================================
// sls_pkg: shared definitions for the sensor lifecycle supervisor
// Codes, field widths, register indexes and the input item type.
// ============================================================================
package sls_pkg;

    // Field widths.
    localparam int TIME_BITS     = 48;
    localparam int CMD_W         = 3;
    localparam int CHAN_W        = 8;
    localparam int OUTCOME_W     = 2;
    localparam int STATUS_W      = 3;
    localparam int STATE_W       = 3;
    localparam int COUNT_W       = 8;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = 64;
    localparam int OUT_DATA_W    = 24;

    // Derived deadline widths.
    localparam int SCALED_W      = 24;
    localparam int WARM_US_W     = 26;
    localparam int DEADLINE_US_W = 35;

    // Constants.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
    localparam int                 US_PER_MS = 1000;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_BIND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POLL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SLEEP = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    // Hook outcomes.
    localparam logic [OUTCOME_W-1:0] HOOK_OK        = 2'd0;
    localparam logic [OUTCOME_W-1:0] HOOK_NOT_READY = 2'd1;

    // Lifecycle states.
    localparam logic [STATE_W-1:0] ST_EMPTY    = 3'd0;
    localparam logic [STATE_W-1:0] ST_IDLE     = 3'd1;
    localparam logic [STATE_W-1:0] ST_WARMUP   = 3'd2;
    localparam logic [STATE_W-1:0] ST_SLEEPING = 3'd3;
    localparam logic [STATE_W-1:0] ST_READING  = 3'd4;
    localparam logic [STATE_W-1:0] ST_READY    = 3'd5;
    localparam logic [STATE_W-1:0] ST_FAULTED  = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] RC_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] RC_NOT_READY  = 3'd1;
    localparam logic [STATUS_W-1:0] RC_BAD_STATE  = 3'd2;
    localparam logic [STATUS_W-1:0] RC_FAULTED    = 3'd3;
    localparam logic [STATUS_W-1:0] RC_NO_CHANNEL = 3'd4;
    localparam logic [STATUS_W-1:0] RC_TIMEOUT    = 3'd5;
    localparam logic [STATUS_W-1:0] RC_HOOK_ERROR = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_WARMUP_MS     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FAULT_THRESH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_FACT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_FLOOR = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HAS_INIT      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HAS_START     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_HAS_SLEEP     = 3'd7;

    // One event as it travels down the input stages.
    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [TIME_BITS-1:0] now_us;
        logic [CHAN_W-1:0]    channel;
        logic [OUTCOME_W-1:0] hook_outcome;
    } item_t;

endpackage

FILE: hw/rtl/sensor_lifecycle_supervisor.sv
// ============================================================================
// sensor_lifecycle_supervisor
// Lifecycle state machine, warmup gating and poll deadline for one sensor.
// ============================================================================
// One event item is accepted per cycle, sustained while m_tready holds no result
// back; each item passes two input registers and is then resolved against the
// lifecycle state in one step that writes the result register and the state
// together, so consecutive items see each other's effect. The poll deadline in
// microseconds is kept in registers derived from the configuration (warmup
// times factor, then the larger of that and the floor, plus one, times 1000);
// after a write it settles through the scaled and deadline registers before
// any item accepted after the write is resolved. Configuration writes are
// taken at once and have no read-back.
module sensor_lifecycle_supervisor
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [sls_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sls_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Event items in.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: now_us[47:0], channel[55:48], hook_outcome[57:56], zero [63:58].
    input  logic [sls_pkg::IN_DATA_W-1:0]       s_tdata,
    // s_tuser: cmd[2:0].
    input  logic [sls_pkg::CMD_W-1:0]           s_tuser,
    // Result items out.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: status[2:0], life_state[5:3], error_count[13:6],
    // reading_valid[14], reading_channel[22:15], zero [23].
    output logic [sls_pkg::OUT_DATA_W-1:0]      m_tdata
);

    // Configuration registers.
    logic [15:0] cfg_warmup_reg;
    logic [7:0]  cfg_chan_count_reg;
    logic [7:0]  cfg_thresh_reg;
    logic [7:0]  cfg_factor_reg;
    logic [15:0] cfg_floor_reg;
    logic        cfg_has_init_reg;
    logic        cfg_has_start_reg;
    logic        cfg_has_sleep_reg;

    // Derived deadline registers.
    logic [sls_pkg::SCALED_W-1:0]      scaled_reg;
    logic [sls_pkg::WARM_US_W-1:0]     warm_us_reg;
    logic [sls_pkg::DEADLINE_US_W-1:0] deadline_us_reg;
    logic [sls_pkg::SCALED_W-1:0]      deadline_ms;

    // Pipeline registers.
    logic                  s1_valid_reg;
    sls_pkg::item_t        s1_item_reg;
    logic                  s2_valid_reg;
    sls_pkg::item_t        s2_item_reg;
    logic                  out_valid_reg;
    logic [sls_pkg::OUT_DATA_W-1:0] out_data_reg;

    // Lifecycle state.
    logic [sls_pkg::STATE_W-1:0]   life_state_reg;
    logic [sls_pkg::COUNT_W-1:0]   err_count_reg;
    logic [sls_pkg::TIME_BITS-1:0] op_start_reg;

    // Next-state values from the resolve step.
    logic [sls_pkg::STATE_W-1:0]   life_state_next;
    logic [sls_pkg::COUNT_W-1:0]   err_count_next;
    logic [sls_pkg::TIME_BITS-1:0] op_start_next;
    logic [sls_pkg::STATUS_W-1:0]  status;
    logic                          got_reading;

    // Flow control.
    logic out_free;
    logic s2_fire;
    logic s1_move;
    logic s_accept;

    sls_pkg::item_t in_item;

    // Timing helpers.
    logic                          now_before_start;
    logic [sls_pkg::TIME_BITS-1:0] elapsed_us;
    logic                          warm_pending;
    logic                          timed_out;

    // Counted-error helpers.
    logic [sls_pkg::COUNT_W-1:0]   err_inc;
    logic                          err_fault;
    logic [sls_pkg::STATE_W-1:0]   after_warmup;
    logic [sls_pkg::STATE_W-1:0]   start_base;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_warmup_reg     <= 16'd0;
            cfg_chan_count_reg <= 8'd1;
            cfg_thresh_reg     <= 8'd3;
            cfg_factor_reg     <= 8'd4;
            cfg_floor_reg      <= 16'd1000;
            cfg_has_init_reg   <= 1'b1;
            cfg_has_start_reg  <= 1'b1;
            cfg_has_sleep_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sls_pkg::REG_WARMUP_MS:     cfg_warmup_reg     <= cfg_data;
                sls_pkg::REG_CHANNEL_COUNT: cfg_chan_count_reg <= cfg_data[7:0];
                sls_pkg::REG_FAULT_THRESH:  cfg_thresh_reg     <= cfg_data[7:0];
                sls_pkg::REG_TIMEOUT_FACT:  cfg_factor_reg     <= cfg_data[7:0];
                sls_pkg::REG_TIMEOUT_FLOOR: cfg_floor_reg      <= cfg_data;
                sls_pkg::REG_HAS_INIT:      cfg_has_init_reg   <= cfg_data[0];
                sls_pkg::REG_HAS_START:     cfg_has_start_reg  <= cfg_data[0];
                sls_pkg::REG_HAS_SLEEP:     cfg_has_sleep_reg  <= cfg_data[0];
                default:                    cfg_warmup_reg     <= cfg_warmup_reg;
            endcase
        end
    end

    // The poll deadline is the larger of the scaled warmup and the floor.
    assign deadline_ms = (scaled_reg > {8'd0, cfg_floor_reg}) ? scaled_reg
                                                              : {8'd0, cfg_floor_reg};

    // Deadline thresholds in microseconds, recomputed every cycle.
    always_ff @(posedge clk)
    begin
        scaled_reg      <= sls_pkg::SCALED_W'({8'd0, cfg_warmup_reg} * {16'd0, cfg_factor_reg});
        warm_us_reg     <= sls_pkg::WARM_US_W'(cfg_warmup_reg * 26'(sls_pkg::US_PER_MS));
        deadline_us_reg <= sls_pkg::DEADLINE_US_W'(
                               ({11'd0, deadline_ms} + 35'd1) * 35'(sls_pkg::US_PER_MS));
    end

    // Unpack the incoming item.
    assign in_item.cmd          = s_tuser;
    assign in_item.now_us       = s_tdata[47:0];
    assign in_item.channel      = s_tdata[55:48];
    assign in_item.hook_outcome = s_tdata[57:56];

    // Each stage moves on when the one after it is empty or moving.
    assign out_free = !out_valid_reg || m_tready;
    assign s2_fire  = s2_valid_reg && out_free;
    assign s1_move  = !s2_valid_reg || out_free;
    assign s_tready = !s1_valid_reg || s1_move;
    assign s_accept = s_tvalid && s_tready;

    // Input stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_move)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_move && s1_valid_reg)
        begin
            s2_item_reg <= s1_item_reg;
        end
    end

    // Elapsed time since the operation start; a clock going backwards reads
    // as no time elapsed.
    assign now_before_start = s2_item_reg.now_us < op_start_reg;
    assign elapsed_us       = s2_item_reg.now_us - op_start_reg;
    assign warm_pending     = now_before_start ? (cfg_warmup_reg != 16'd0)
                                               : (elapsed_us < {22'd0, warm_us_reg});
    assign timed_out        = !now_before_start && !(elapsed_us < {13'd0, deadline_us_reg});

    // A counted error saturates the count and faults at the threshold.
    assign err_inc   = (err_count_reg != sls_pkg::COUNT_MAX) ? err_count_reg + 8'd1
                                                             : err_count_reg;
    assign err_fault = err_inc >= cfg_thresh_reg;

    assign after_warmup = (cfg_warmup_reg != 16'd0) ? sls_pkg::ST_WARMUP : sls_pkg::ST_IDLE;

    // Start read passes through idle when leaving warmup or sleep.
    assign start_base = (life_state_reg == sls_pkg::ST_WARMUP ||
                         life_state_reg == sls_pkg::ST_SLEEPING) ? sls_pkg::ST_IDLE
                                                                 : life_state_reg;

    // Resolve one event against the lifecycle state.
    always_comb
    begin
        life_state_next = life_state_reg;
        err_count_next  = err_count_reg;
        op_start_next   = op_start_reg;
        status          = sls_pkg::RC_BAD_STATE;
        got_reading     = 1'b0;

        unique case (s2_item_reg.cmd)
            sls_pkg::CMD_BIND:
            begin
                if (cfg_chan_count_reg != 8'd0)
                begin
                    err_count_next = 8'd0;
                    op_start_next  = s2_item_reg.now_us;
                    if (cfg_has_init_reg && s2_item_reg.hook_outcome != sls_pkg::HOOK_OK)
                    begin
                        life_state_next = sls_pkg::ST_FAULTED;
                        err_count_next  = cfg_thresh_reg;
                        status = (s2_item_reg.hook_outcome == sls_pkg::HOOK_NOT_READY)
                                 ? sls_pkg::RC_NOT_READY : sls_pkg::RC_HOOK_ERROR;
                    end
                    else
                    begin
                        life_state_next = after_warmup;
                        status          = sls_pkg::RC_OK;
                    end
                end
            end

            sls_pkg::CMD_START:
            begin
                priority if (life_state_reg == sls_pkg::ST_FAULTED)
                begin
                    status = sls_pkg::RC_FAULTED;
                end
                else if (life_state_reg == sls_pkg::ST_READING)
                begin
                    status = sls_pkg::RC_NOT_READY;
                end
                else if (life_state_reg == sls_pkg::ST_WARMUP && warm_pending)
                begin
                    status = sls_pkg::RC_NOT_READY;
                end
                else if (life_state_reg == sls_pkg::ST_SLEEPING &&
                         cfg_warmup_reg != 16'd0)
                begin
                    // Waking a sleeping sensor with a warmup restarts warmup.
                    op_start_next   = s2_item_reg.now_us;
                    life_state_next = sls_pkg::ST_WARMUP;
                    status          = sls_pkg::RC_NOT_READY;
                end
                else if (life_state_reg == sls_pkg::ST_WARMUP ||
                         life_state_reg == sls_pkg::ST_SLEEPING ||
                         life_state_reg == sls_pkg::ST_IDLE ||
                         life_state_reg == sls_pkg::ST_READY)
                begin
                    op_start_next = s2_item_reg.now_us;
                    if (!cfg_has_start_reg || s2_item_reg.hook_outcome == sls_pkg::HOOK_OK)
                    begin
                        life_state_next = sls_pkg::ST_READING;
                        status          = sls_pkg::RC_OK;
                    end
                    else if (s2_item_reg.hook_outcome == sls_pkg::HOOK_NOT_READY)
                    begin
                        life_state_next = start_base;
                        status          = sls_pkg::RC_NOT_READY;
                    end
                    else
                    begin
                        err_count_next  = err_inc;
                        life_state_next = err_fault ? sls_pkg::ST_FAULTED : start_base;
                        status          = sls_pkg::RC_HOOK_ERROR;
                    end
                end
                else
                begin
                    status = sls_pkg::RC_BAD_STATE;
                end
            end

            sls_pkg::CMD_POLL:
            begin
                priority if (life_state_reg == sls_pkg::ST_EMPTY)
                begin
                    status = sls_pkg::RC_BAD_STATE;
                end
                else if (life_state_reg == sls_pkg::ST_FAULTED)
                begin
                    status = sls_pkg::RC_FAULTED;
                end
                else if (s2_item_reg.channel >= cfg_chan_count_reg)
                begin
                    status = sls_pkg::RC_NO_CHANNEL;
                end
                else if (life_state_reg != sls_pkg::ST_READING &&
                         life_state_reg != sls_pkg::ST_READY)
                begin
                    status = sls_pkg::RC_BAD_STATE;
                end
                else if (s2_item_reg.hook_outcome == sls_pkg::HOOK_OK)
                begin
                    got_reading     = 1'b1;
                    life_state_next = sls_pkg::ST_READY;
                    err_count_next  = 8'd0;
                    status          = sls_pkg::RC_OK;
                end
                else if (s2_item_reg.hook_outcome == sls_pkg::HOOK_NOT_READY && !timed_out)
                begin
                    status = sls_pkg::RC_NOT_READY;
                end
                else
                begin
                    // A stale not-ready poll counts as a timeout.
                    err_count_next  = err_inc;
                    life_state_next = err_fault ? sls_pkg::ST_FAULTED : sls_pkg::ST_IDLE;
                    status = (s2_item_reg.hook_outcome == sls_pkg::HOOK_NOT_READY)
                             ? sls_pkg::RC_TIMEOUT : sls_pkg::RC_HOOK_ERROR;
                end
            end

            sls_pkg::CMD_SLEEP:
            begin
                priority if (life_state_reg == sls_pkg::ST_FAULTED)
                begin
                    status = sls_pkg::RC_FAULTED;
                end
                else if (life_state_reg == sls_pkg::ST_EMPTY ||
                         life_state_reg > sls_pkg::ST_FAULTED)
                begin
                    status = sls_pkg::RC_BAD_STATE;
                end
                else if (!cfg_has_sleep_reg || s2_item_reg.hook_outcome == sls_pkg::HOOK_OK)
                begin
                    life_state_next = sls_pkg::ST_SLEEPING;
                    status          = sls_pkg::RC_OK;
                end
                else if (s2_item_reg.hook_outcome == sls_pkg::HOOK_NOT_READY)
                begin
                    status = sls_pkg::RC_NOT_READY;
                end
                else
                begin
                    err_count_next  = err_inc;
                    life_state_next = err_fault ? sls_pkg::ST_FAULTED : life_state_reg;
                    status          = sls_pkg::RC_HOOK_ERROR;
                end
            end

            sls_pkg::CMD_CLEAR:
            begin
                status = sls_pkg::RC_OK;
                if (life_state_reg == sls_pkg::ST_FAULTED)
                begin
                    err_count_next  = 8'd0;
                    op_start_next   = s2_item_reg.now_us;
                    life_state_next = after_warmup;
                end
            end

            default:
            begin
                status = sls_pkg::RC_BAD_STATE;
            end
        endcase
    end

    // Lifecycle state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            life_state_reg <= sls_pkg::ST_EMPTY;
            err_count_reg  <= 8'd0;
            op_start_reg   <= '0;
        end
        else if (s2_fire)
        begin
            life_state_reg <= life_state_next;
            err_count_reg  <= err_count_next;
            op_start_reg   <= op_start_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            out_data_reg <= {1'b0,
                             got_reading ? s2_item_reg.channel : 8'd0,
                             got_reading,
                             err_count_next,
                             life_state_next,
                             status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
